@@ rtl/sycc_pkg.sv @@
// Shared types and constants for the YCbCr-to-RGB upsampling converter.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package sycc_pkg;

	// Chroma subsampling modes as written to the mode register.
	typedef enum logic [1:0] {
		MODE_444 = 2'd0,
		MODE_422 = 2'd1,
		MODE_420 = 2'd2
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_CHROMA_MODE = 2'd0,
		REG_PRECISION   = 2'd1,
		REG_WIDTH       = 2'd2,
		REG_HEIGHT      = 2'd3
	} reg_t;

	// Where a pixel takes its chroma pair from.
	typedef enum logic [1:0] {
		SRC_HOLD  = 2'd0,
		SRC_FRESH = 2'd1,
		SRC_LINE  = 2'd2
	} src_t;

	// Reset values of the configuration registers, and the precision limits.
	localparam logic [4:0]  PREC_RESET   = 5'd8;
	localparam logic [4:0]  PREC_MIN     = 5'd1;
	localparam logic [4:0]  PREC_MAX     = 5'd16;
	localparam logic [12:0] WIDTH_RESET  = 13'd1;
	localparam logic [15:0] HEIGHT_RESET = 16'd1;

	// Q16 conversion coefficients: 1.402, 0.344, 0.714, 1.772.
	localparam logic signed [17:0] COEF_CR_R = 18'sd91881;
	localparam logic signed [17:0] COEF_CB_G = 18'sd22544;
	localparam logic signed [17:0] COEF_CR_G = 18'sd46793;
	localparam logic signed [17:0] COEF_CB_B = 18'sd116130;

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// Chroma pair, laid out as the held register: Cr high, Cb low.
	typedef struct packed {
		logic [15:0] cr;
		logic [15:0] cb;
	} chroma_t;

	// Input pixel transaction.
	typedef struct packed {
		logic [15:0] luma;
		logic [15:0] blue_diff;
		logic [15:0] red_diff;
	} pix_in_t;

	// Output pixel transaction.
	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        frame_end;
	} pix_out_t;

	// Classified pixel carried from the front part to the back part.
	typedef struct packed {
		logic [15:0] luma;
		chroma_t     chroma;
		logic        frame_end;
	} item_t;

	// Effective configuration, already limited to legal ranges where fixed.
	typedef struct packed {
		mode_t       mode;
		logic [4:0]  prec;
		logic [12:0] width;
		logic [15:0] height;
	} cfg_t;

endpackage

@@ rtl/sycc_front.sv @@
// Front part: accepts pixels, tracks row and column, picks the chroma pair.
// Holds the chroma line store. Depends on sycc_pkg.
`timescale 1ns / 1ps

module sycc_front #(
	parameter int MAX_LINE_WIDTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sycc_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  sycc_pkg::pix_in_t in_data,
	output logic             q_valid,
	input  logic             q_ready,
	output sycc_pkg::item_t  q_item
);

	localparam int CW = $clog2(MAX_LINE_WIDTH);
	localparam int LD = (MAX_LINE_WIDTH + 1) / 2;
	localparam int AW = (LD > 1) ? $clog2(LD) : 1;

	logic [CW-1:0]         col_q;
	logic [15:0]           row_q;
	sycc_pkg::chroma_t     held_q;
	logic [CW:0]           w_eff;
	logic [CW:0]           col_inc;
	logic [15:0]           h_eff;
	logic [16:0]           row_inc;
	logic                  row_end;
	logic                  frame_end;
	logic                  acc;
	logic                  push;
	logic                  even_col;
	logic                  odd_row_420;
	logic                  wr_line;
	sycc_pkg::src_t        src;
	logic [AW-1:0]         slot;
	sycc_pkg::chroma_t     fresh;
	sycc_pkg::chroma_t     line_mem [LD];

	logic                  v_s1;
	logic [15:0]           y_s1;
	sycc_pkg::chroma_t     fresh_s1;
	sycc_pkg::chroma_t     line_s1;
	sycc_pkg::src_t        src_s1;
	logic                  fe_s1;
	sycc_pkg::chroma_t     chroma_s1;

	// Handshakes: the stage takes a new transaction when empty or draining.
	assign push     = v_s1 && q_ready;
	assign in_ready = !v_s1 || q_ready;
	assign acc      = in_valid && in_ready;

	// Effective frame sizes.
	always_comb begin
		if (cfg.width == '0) begin
			w_eff = (CW+1)'(1);
		end else if (32'(cfg.width) > MAX_LINE_WIDTH) begin
			w_eff = (CW+1)'(MAX_LINE_WIDTH);
		end else begin
			w_eff = (CW+1)'(cfg.width);
		end
	end
	assign h_eff = (cfg.height == '0) ? 16'd1 : cfg.height;

	// Row and frame end detection.
	assign col_inc   = (CW+1)'(col_q) + (CW+1)'(1);
	assign row_inc   = {1'b0, row_q} + 17'd1;
	assign row_end   = (col_inc >= w_eff);
	assign frame_end = row_end && (row_inc >= {1'b0, h_eff});

	// Chroma source classification.
	assign even_col    = !col_q[0];
	assign odd_row_420 = (cfg.mode == sycc_pkg::MODE_420) && row_q[0];
	assign wr_line     = (cfg.mode == sycc_pkg::MODE_420) && !row_q[0] && even_col;
	always_comb begin
		if (cfg.mode == sycc_pkg::MODE_444) begin
			src = sycc_pkg::SRC_FRESH;
		end else if (!even_col) begin
			src = sycc_pkg::SRC_HOLD;
		end else if (odd_row_420) begin
			src = sycc_pkg::SRC_LINE;
		end else begin
			src = sycc_pkg::SRC_FRESH;
		end
	end

	assign slot     = AW'(col_q >> 1);
	assign fresh.cb = in_data.blue_diff;
	assign fresh.cr = in_data.red_diff;

	// Pixel position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_inc[15:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Line store: even 4:2:0 rows write, odd rows read back; read data registered.
	always_ff @(posedge clk) begin
		if (acc) begin
			if (wr_line) begin
				line_mem[slot] <= fresh;
			end else begin
				line_s1 <= line_mem[slot];
			end
		end
	end

	// Stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			y_s1     <= in_data.luma;
			fresh_s1 <= fresh;
			src_s1   <= src;
			fe_s1    <= frame_end;
		end
	end

	// Resolve the chroma pair for the pixel in stage one.
	always_comb begin
		unique case (src_s1)
			sycc_pkg::SRC_FRESH: chroma_s1 = fresh_s1;
			sycc_pkg::SRC_LINE:  chroma_s1 = line_s1;
			default:             chroma_s1 = held_q;
		endcase
	end

	// Held chroma pair follows every pixel that leaves the front part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (push) begin
			held_q <= chroma_s1;
		end
	end

	assign q_valid          = v_s1;
	assign q_item.luma      = y_s1;
	assign q_item.chroma    = chroma_s1;
	assign q_item.frame_end = fe_s1;

`ifndef NO_ASSERTIONS
	// An accepted transaction occupies stage one on the next cycle.
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("front stage lost an accepted pixel");

	// The held pair is the chroma of the last pixel sent on.
	a_held: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (held_q == $past(chroma_s1)))
		else $error("held chroma does not follow the last pixel");

	// The last pixel of a frame brings both counters back to zero.
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && frame_end) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at frame end");
`endif

endmodule

@@ rtl/sycc_fifo.sv @@
// Short queue of classified pixels between the front and back parts.
// Depends on sycc_pkg for the item type and depth.
`timescale 1ns / 1ps

module sycc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  sycc_pkg::item_t push_item,
	output logic            pop_valid,
	input  logic            pop_ready,
	output sycc_pkg::item_t pop_item
);

	sycc_pkg::item_t             store_q [sycc_pkg::QDEPTH];
	logic [sycc_pkg::QAW-1:0]    wr_ptr_q;
	logic [sycc_pkg::QAW-1:0]    rd_ptr_q;
	logic [sycc_pkg::QAW:0]      cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (cnt_q != (sycc_pkg::QAW+1)'(sycc_pkg::QDEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = store_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + (sycc_pkg::QAW)'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + (sycc_pkg::QAW)'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (sycc_pkg::QAW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (sycc_pkg::QAW+1)'(1);
			end
		end
	end

endmodule

@@ rtl/sycc_back.sv @@
// Back part: pipelined Q16 color conversion, clamping and output register.
// Depends on sycc_pkg.
`timescale 1ns / 1ps

module sycc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [4:0]         prec,
	input  logic               q_valid,
	output logic               q_ready,
	input  sycc_pkg::item_t    q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output sycc_pkg::pix_out_t out_data
);

	logic                      adv;
	logic [16:0]               off_w;
	logic [16:0]               upb_w;
	logic [15:0]               offset;
	logic [15:0]               upb;

	logic                      v_s1, v_s2, v_s3, out_valid_q;
	logic [15:0]               y_s1, y_s2, y_s3;
	logic                      fe_s1, fe_s2, fe_s3;
	logic signed [17:0]        cb_s1, cr_s1;
	logic signed [35:0]        pr_s2, pgb_s2, pgr_s2, pb_s2;
	logic signed [20:0]        tr_s3, tg_s3, tb_s3;
	logic signed [21:0]        sum_r, sum_g, sum_b;
	sycc_pkg::pix_out_t        out_q;

	// Divide by 2^16 with rounding toward zero.
	function automatic logic signed [20:0] q16_trunc(input logic signed [36:0] p);
		logic signed [36:0] adj;
		adj = p + (p[36] ? 37'sd65535 : 37'sd0);
		return 21'(adj >>> 16);
	endfunction

	// Clamp to zero and the precision's upper bound.
	function automatic logic [15:0] clamp(input logic signed [21:0] v,
			input logic [15:0] hi);
		logic [15:0] res;
		if (v < 0) begin
			res = '0;
		end else if (v > $signed({6'b0, hi})) begin
			res = hi;
		end else begin
			res = v[15:0];
		end
		return res;
	endfunction

	// Offset and upper bound from the effective precision.
	assign off_w  = 17'd1 << (prec - 5'd1);
	assign upb_w  = (17'd1 << prec) - 17'd1;
	assign offset = off_w[15:0];
	assign upb    = upb_w[15:0];

	// The whole pipeline moves unless the output register is stalled.
	assign adv     = !out_valid_q || out_ready;
	assign q_ready = adv;

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	// Stage one: remove the chroma offset.
	always_ff @(posedge clk) begin
		if (adv) begin
			y_s1  <= q_item.luma;
			fe_s1 <= q_item.frame_end;
			cb_s1 <= $signed({2'b00, q_item.chroma.cb}) - $signed({2'b00, offset});
			cr_s1 <= $signed({2'b00, q_item.chroma.cr}) - $signed({2'b00, offset});
		end
	end

	// Stage two: the four coefficient products.
	always_ff @(posedge clk) begin
		if (adv) begin
			y_s2   <= y_s1;
			fe_s2  <= fe_s1;
			pr_s2  <= cr_s1 * sycc_pkg::COEF_CR_R;
			pgb_s2 <= cb_s1 * sycc_pkg::COEF_CB_G;
			pgr_s2 <= cr_s1 * sycc_pkg::COEF_CR_G;
			pb_s2  <= cb_s1 * sycc_pkg::COEF_CB_B;
		end
	end

	// Stage three: green sum and truncation of each correction term.
	always_ff @(posedge clk) begin
		if (adv) begin
			y_s3  <= y_s2;
			fe_s3 <= fe_s2;
			tr_s3 <= q16_trunc(37'(pr_s2));
			tg_s3 <= q16_trunc(37'(pgb_s2) + 37'(pgr_s2));
			tb_s3 <= q16_trunc(37'(pb_s2));
		end
	end

	// Output stage: apply the corrections to luma and clamp.
	assign sum_r = $signed({6'b0, y_s3}) + 22'(tr_s3);
	assign sum_g = $signed({6'b0, y_s3}) - 22'(tg_s3);
	assign sum_b = $signed({6'b0, y_s3}) + 22'(tb_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.red       <= clamp(sum_r, upb);
			out_q.green     <= clamp(sum_g, upb);
			out_q.blue      <= clamp(sum_b, upb);
			out_q.frame_end <= fe_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ rtl/sycc_upsample_to_rgb_core.sv @@
// Top level of the YCbCr-to-RGB converter with chroma upsampling.
// Instantiates sycc_front, sycc_fifo and sycc_back; depends on sycc_pkg.
`timescale 1ns / 1ps

// Converts a raster stream of luma pixels with 4:4:4, 4:2:2 or 4:2:0 chroma
// into one RGB pixel per input pixel, using BT.601 Q16 coefficients and
// clamping to the configured sample precision. It sustains one pixel per
// clock while the output is not stalled: the front stage, the four-entry queue
// and the four-stage conversion pipeline each take a new transaction every
// cycle, and the single-port chroma line store is read or written once per
// pixel. The line store starts undefined and needs no clearing pass; the user
// must write configuration only while idle, which the block does not enforce.
module sycc_upsample_to_rgb_core #(
	parameter int MAX_LINE_WIDTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sycc_pkg::pix_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output sycc_pkg::pix_out_t out_data,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_wdata
);

	logic [1:0]       mode_q;
	logic [4:0]       prec_q;
	logic [12:0]      width_q;
	logic [15:0]      height_q;
	sycc_pkg::cfg_t   cfg;
	logic             q_push_valid;
	logic             q_push_ready;
	sycc_pkg::item_t  q_push_item;
	logic             q_pop_valid;
	logic             q_pop_ready;
	sycc_pkg::item_t  q_pop_item;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= sycc_pkg::MODE_444;
			prec_q   <= sycc_pkg::PREC_RESET;
			width_q  <= sycc_pkg::WIDTH_RESET;
			height_q <= sycc_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sycc_pkg::REG_CHROMA_MODE: mode_q   <= cfg_wdata[1:0];
				sycc_pkg::REG_PRECISION:   prec_q   <= cfg_wdata[4:0];
				sycc_pkg::REG_WIDTH:       width_q  <= cfg_wdata[12:0];
				sycc_pkg::REG_HEIGHT:      height_q <= cfg_wdata[15:0];
				default:                   mode_q   <= mode_q;
			endcase
		end
	end

	// Effective configuration: the unused mode acts as 4:4:4, precision is limited.
	always_comb begin
		if (mode_q == sycc_pkg::MODE_422 || mode_q == sycc_pkg::MODE_420) begin
			cfg.mode = sycc_pkg::mode_t'(mode_q);
		end else begin
			cfg.mode = sycc_pkg::MODE_444;
		end
		if (prec_q < sycc_pkg::PREC_MIN) begin
			cfg.prec = sycc_pkg::PREC_MIN;
		end else if (prec_q > sycc_pkg::PREC_MAX) begin
			cfg.prec = sycc_pkg::PREC_MAX;
		end else begin
			cfg.prec = prec_q;
		end
		cfg.width  = width_q;
		cfg.height = height_q;
	end

	// Front part: position tracking and chroma selection.
	sycc_front #(
		.MAX_LINE_WIDTH(MAX_LINE_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_push_valid),
		.q_ready  (q_push_ready),
		.q_item   (q_push_item)
	);

	// Queue between the two parts.
	sycc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_ready (q_push_ready),
		.push_item  (q_push_item),
		.pop_valid  (q_pop_valid),
		.pop_ready  (q_pop_ready),
		.pop_item   (q_pop_item)
	);

	// Back part: color conversion pipeline.
	sycc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.prec      (cfg.prec),
		.q_valid   (q_pop_valid),
		.q_ready   (q_pop_ready),
		.q_item    (q_pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for sycc_upsample_to_rgb_core. It streams pixels in every
// chroma mode and checks each RGB transaction against an in-bench predictor.
// Depends on sycc_pkg and the core RTL under rtl/.

module testbench;

	localparam int LINE_MAX = 4096;
	localparam int LINE_SLOTS = (LINE_MAX + 1) / 2;
	localparam int MAX_GAP = 17;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PIXELS = 700;
	localparam int LONG_LINE = 256;
	localparam int REPORT_LIMIT = 10;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Q16 conversion coefficients for 1.402, 0.344, 0.714 and 1.772.
	localparam longint K_CR_R = 91881;
	localparam longint K_CB_G = 22544;
	localparam longint K_CR_G = 46793;
	localparam longint K_CB_B = 116130;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	sycc_pkg::pix_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	sycc_pkg::pix_out_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = sycc_pkg::REG_CHROMA_MODE;
	logic [15:0] cfg_wdata = '0;

	// Predictor copy of the registers and the pixel state.
	logic [1:0] cfg_mode = sycc_pkg::MODE_444;
	logic [4:0] cfg_prec = sycc_pkg::PREC_RESET;
	logic [12:0] cfg_width = sycc_pkg::WIDTH_RESET;
	logic [15:0] cfg_height = sycc_pkg::HEIGHT_RESET;
	int unsigned col_count = 0;
	int unsigned row_count = 0;
	sycc_pkg::chroma_t held_pair = '0;
	sycc_pkg::chroma_t line_pairs [LINE_SLOTS];

	sycc_pkg::pix_out_t rgb_pending [$];
	int mismatch_count = 0;
	int pixels_sent = 0;
	int stuck_cycles = 0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;

	sycc_upsample_to_rgb_core #(
		.MAX_LINE_WIDTH(LINE_MAX)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Effective register values after the out-of-range rules.
	function automatic int unsigned eff_prec();
		if (cfg_prec < sycc_pkg::PREC_MIN)
			return sycc_pkg::PREC_MIN;
		if (cfg_prec > sycc_pkg::PREC_MAX)
			return sycc_pkg::PREC_MAX;
		return cfg_prec;
	endfunction

	function automatic int unsigned eff_width();
		if (cfg_width == 0)
			return 1;
		if (cfg_width > LINE_MAX)
			return LINE_MAX;
		return cfg_width;
	endfunction

	function automatic int unsigned eff_height();
		return (cfg_height == 0) ? 1 : cfg_height;
	endfunction

	// Division by 2^16 that rounds toward zero.
	function automatic longint q16_trunc(longint prod);
		if (prod < 0)
			return -((-prod) >>> 16);
		return prod >>> 16;
	endfunction

	function automatic logic [15:0] clamp_sample(longint v, longint upb);
		if (v < 0)
			return '0;
		if (v > upb)
			return 16'(upb);
		return 16'(v);
	endfunction

	// Works out the RGB pixel for one accepted input pixel and advances the raster position.
	function automatic sycc_pkg::pix_out_t convert_pixel(sycc_pkg::pix_in_t px);
		int unsigned prec, wid, hgt, slot;
		logic [1:0] mode;
		sycc_pkg::chroma_t fresh;
		longint y, cb, cr, offs, upb;
		bit row_done, frame_done;
		sycc_pkg::pix_out_t res;
		prec = eff_prec();
		wid = eff_width();
		hgt = eff_height();
		mode = cfg_mode;
		if (mode != sycc_pkg::MODE_422 && mode != sycc_pkg::MODE_420)
			mode = sycc_pkg::MODE_444;
		fresh.cb = px.blue_diff;
		fresh.cr = px.red_diff;
		slot = (col_count >> 1) % LINE_SLOTS;

		// Pick the chroma pair: fresh input, the held pair, or the line above in 4:2:0.
		if (mode == sycc_pkg::MODE_444) begin
			held_pair = fresh;
		end else if (!col_count[0]) begin
			if (mode == sycc_pkg::MODE_420 && row_count[0]) begin
				held_pair = line_pairs[slot];
			end else begin
				held_pair = fresh;
				if (mode == sycc_pkg::MODE_420)
					line_pairs[slot] = fresh;
			end
		end

		offs = longint'(1) << (prec - 1);
		upb = (longint'(1) << prec) - 1;
		y = longint'(px.luma);
		cb = longint'(held_pair.cb) - offs;
		cr = longint'(held_pair.cr) - offs;
		res.red = clamp_sample(y + q16_trunc(K_CR_R * cr), upb);
		res.green = clamp_sample(y - q16_trunc(K_CB_G * cb + K_CR_G * cr), upb);
		res.blue = clamp_sample(y + q16_trunc(K_CB_B * cb), upb);

		// Counters left beyond the last column or row by a reconfiguration wrap here.
		row_done = (col_count + 1 >= wid);
		frame_done = row_done && (row_count + 1 >= hgt);
		res.frame_end = frame_done;
		if (frame_done) begin
			col_count = 0;
			row_count = 0;
		end else if (row_done) begin
			col_count = 0;
			row_count = (row_count + 1) & 16'hFFFF;
		end else begin
			col_count = col_count + 1;
		end
		return res;
	endfunction

	// Sample values weighted toward the extremes of the current precision.
	function automatic logic [15:0] pick_sample(int unsigned prec);
		logic [15:0] top;
		top = 16'((longint'(1) << prec) - 1);
		case ($urandom_range(0, 7))
			0: return 16'($urandom);
			1: return '0;
			2: return top;
			3: return 16'(longint'(1) << (prec - 1));
			default: return 16'($urandom_range(0, top));
		endcase
	endfunction

	task automatic write_reg(sycc_pkg::reg_t idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			sycc_pkg::REG_CHROMA_MODE: cfg_mode = val[1:0];
			sycc_pkg::REG_PRECISION: cfg_prec = val[4:0];
			sycc_pkg::REG_WIDTH: cfg_width = val[12:0];
			sycc_pkg::REG_HEIGHT: cfg_height = val;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Sends one pixel transaction; valid stays high after acceptance for back-to-back use.
	task automatic send_pixel(sycc_pkg::pix_in_t px);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= px;
		do @(posedge clk); while (!in_ready);
		rgb_pending.push_back(convert_pixel(px));
		pixels_sent++;
	endtask

	task automatic send_ycc(logic [15:0] y, logic [15:0] cb, logic [15:0] cr);
		sycc_pkg::pix_in_t px;
		px.luma = y;
		px.blue_diff = cb;
		px.red_diff = cr;
		send_pixel(px);
	endtask

	task automatic send_random_pixels(int n);
		int unsigned prec;
		repeat (n) begin
			prec = eff_prec();
			send_ycc(pick_sample(prec), pick_sample(prec), pick_sample(prec));
		end
	endtask

	// Drops valid and waits until every predicted pixel has come out.
	task automatic finish_phase();
		in_valid <= 1'b0;
		while (rgb_pending.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Reset values: 4:4:4, 8-bit samples, a 1x1 frame, so every pixel ends a frame.
	task automatic test_reset_defaults();
		send_ycc(16'h0000, 16'h0000, 16'h0000);
		send_ycc(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_ycc(16'h0080, 16'h0080, 16'h0080);
		send_ycc(16'h00FF, 16'h0000, 16'h00FF);
		send_ycc(16'h0000, 16'h00FF, 16'h0000);
		send_ycc(16'h5555, 16'hAAAA, 16'h5555);
		finish_phase();
	endtask

	// Subsampled modes on odd frame sizes, where the last chroma sample covers one pixel.
	task automatic test_subsampled_modes();
		write_reg(sycc_pkg::REG_CHROMA_MODE, 16'(sycc_pkg::MODE_422));
		write_reg(sycc_pkg::REG_WIDTH, 16'd3);
		write_reg(sycc_pkg::REG_HEIGHT, 16'd1);
		send_random_pixels(3);
		finish_phase();
		write_reg(sycc_pkg::REG_CHROMA_MODE, 16'(sycc_pkg::MODE_420));
		write_reg(sycc_pkg::REG_HEIGHT, 16'd3);
		send_random_pixels(9);
		finish_phase();
	endtask

	// Unused mode, zero precision, zero sizes, then precision above the maximum.
	task automatic test_out_of_range_regs();
		write_reg(sycc_pkg::REG_CHROMA_MODE, 16'(MODE_UNUSED));
		write_reg(sycc_pkg::REG_PRECISION, 16'd0);
		write_reg(sycc_pkg::REG_WIDTH, 16'd0);
		write_reg(sycc_pkg::REG_HEIGHT, 16'd0);
		send_random_pixels(2);
		finish_phase();
		write_reg(sycc_pkg::REG_PRECISION, 16'hFFFF);
		send_ycc(16'hFFFF, 16'hFFFF, 16'h0000);
		send_ycc(16'h0000, 16'h0000, 16'hFFFF);
		finish_phase();
	endtask

	// Shrinking the frame mid-frame leaves the counters past the last column and row.
	task automatic test_midframe_reconfig();
		write_reg(sycc_pkg::REG_CHROMA_MODE, 16'(sycc_pkg::MODE_422));
		write_reg(sycc_pkg::REG_PRECISION, 16'd8);
		write_reg(sycc_pkg::REG_WIDTH, 16'd4);
		write_reg(sycc_pkg::REG_HEIGHT, 16'd3);
		send_random_pixels(5);
		finish_phase();
		write_reg(sycc_pkg::REG_WIDTH, 16'd1);
		write_reg(sycc_pkg::REG_HEIGHT, 16'd1);
		write_reg(sycc_pkg::REG_PRECISION, 16'd12);
		send_random_pixels(1);
		finish_phase();
	endtask

	// A long 4:2:0 line fills and reads back a long run of line store entries.
	task automatic test_full_line();
		write_reg(sycc_pkg::REG_CHROMA_MODE, 16'(sycc_pkg::MODE_420));
		write_reg(sycc_pkg::REG_PRECISION, 16'(sycc_pkg::PREC_MAX));
		write_reg(sycc_pkg::REG_WIDTH, 16'(LONG_LINE));
		write_reg(sycc_pkg::REG_HEIGHT, 16'd2);
		send_random_pixels(2 * LONG_LINE);
		finish_phase();
	endtask

	// Random settings between whole frames, with random pixel content.
	task automatic test_random_frames();
		int first;
		int frames;
		logic [15:0] val;
		first = pixels_sent;
		while (pixels_sent - first < RANDOM_PIXELS) begin
			send_steady = ($urandom_range(0, 3) == 0);
			recv_steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 1)) begin
				val = 16'($urandom_range(sycc_pkg::MODE_444, MODE_UNUSED));
				if ($urandom_range(0, 3) == 0)
					val[15:2] = 14'($urandom);
				write_reg(sycc_pkg::REG_CHROMA_MODE, val);
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					8: val = 16'd0;
					9: val = 16'($urandom);
					default: val = 16'($urandom_range(sycc_pkg::PREC_MIN,
						sycc_pkg::PREC_MAX));
				endcase
				write_reg(sycc_pkg::REG_PRECISION, val);
			end
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 9))
					6, 7: val = 16'($urandom_range(9, 40));
					8: val = 16'd0;
					9: val = {3'($urandom), 13'($urandom_range(1, 8))};
					default: val = 16'($urandom_range(1, 8));
				endcase
				write_reg(sycc_pkg::REG_WIDTH, val);
			end
			if ($urandom_range(0, 1))
				write_reg(sycc_pkg::REG_HEIGHT, 16'($urandom_range(0, 6)));
			frames = $urandom_range(1, 3);
			send_random_pixels(frames * eff_width() * eff_height());
			finish_phase();
		end
		send_steady = 1'b0;
		recv_steady = 1'b0;
	endtask

	// Output side: a random stall before each RGB transaction.
	initial begin : rgb_sink
		int stall;
		forever begin
			stall = recv_steady ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compares every accepted RGB transaction with the oldest predicted pixel.
	always @(posedge clk) begin : rgb_check
		sycc_pkg::pix_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (rgb_pending.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("%0t: unexpected RGB transaction r=%h g=%h b=%h end=%b",
						$time, out_data.red, out_data.green, out_data.blue,
						out_data.frame_end);
			end else begin
				want = rgb_pending.pop_front();
				if (out_data.red !== want.red || out_data.green !== want.green ||
						out_data.blue !== want.blue ||
						out_data.frame_end !== want.frame_end) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("%0t: RGB mismatch, expected r=%h g=%h b=%h end=%b",
							$time, want.red, want.green, want.blue, want.frame_end);
						$display("%0t: RGB mismatch, got r=%h g=%h b=%h end=%b",
							$time, out_data.red, out_data.green, out_data.blue,
							out_data.frame_end);
					end
				end
			end
		end
	end

	// Watchdog: ends the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_subsampled_modes();
		test_out_of_range_regs();
		test_midframe_reconfig();
		test_full_line();
		test_random_frames();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && rgb_pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/sycc_pkg.sv
rtl/sycc_front.sv
rtl/sycc_fifo.sv
rtl/sycc_back.sv
rtl/sycc_upsample_to_rgb_core.sv
tb/testbench.sv
